FILE: design/tcw_pkg.sv
// types and constants shared by the text console writer
// depends on nothing; imported by text_console_writer_core
package tcw_pkg;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [15:0] BLANK_CELL = 16'h0020;
    localparam logic [15:0] ERASED_CELL = 16'h0000;
    localparam int TAB_SPACES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } tcw_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
    } tcw_result_t;

endpackage

FILE: design/tcw_screen_mem.sv
// screen cell store: one write port, one registered read port
// depends on nothing
module tcw_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/text_console_writer_core.sv
// text console writer top level: sequencer, per-line column ring, row valid bits
// depends on tcw_pkg and tcw_screen_mem
//
//   channel   direction   handshake              payload
//   in        to core     in_valid / in_stall    in_data  (tcw_item_t)
//   out       from core   out_valid / out_stall  out_data (tcw_result_t)
//   cfg       to core     cfg_we                 cfg_data (text color)
//
// one beat at a time: nop, clear, newline, backspace at column 0 and an out-of-range
// read go from S_DISPATCH to S_FINISH; an in-range read adds S_READ, an erasing
// backspace S_PUT, a printable S_PRINT and S_PUT (S_PRINT again on a wrap), a tab four.
// a write that lands on a row scrolled in or cleared since its last fill first
// fills that row with blanks through the single memory write port.
// reset and screen clear drop the row valid bits and zero the line columns; no memory pass is needed.
// a result waits in the output register while out_stall holds; input is taken
// again once the previous result is loaded there.
module text_console_writer_core #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcw_pkg::tcw_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tcw_pkg::tcw_result_t out_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data
);
    import tcw_pkg::*;

    localparam int CW    = $clog2(COLS + 1);
    localparam int SCW   = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PRINT,
        S_PUT,
        S_SWEEP,
        S_READ,
        S_FINISH
    } state_t;

    state_t          state_reg;
    tcw_item_t       item_reg;
    logic [7:0]      text_color_reg;
    logic [CW-1:0]   lc_reg [ROWS];
    logic [RW-1:0]   lc_bot_reg;
    logic [RW-1:0]   row_base_reg;
    logic [RW-1:0]   scr_bot_reg;
    logic [ROWS-1:0] row_valid_reg;
    logic [1:0]      rep_reg;
    logic [SCW-1:0]  wr_col_reg;
    logic [15:0]     wr_data_reg;
    logic [SCW-1:0]  sweep_reg;
    logic            rd_valid_reg;
    logic [15:0]     cell_reg;
    logic            out_valid_reg;
    tcw_result_t     out_data_reg;

    logic [CW-1:0]   cur_col;
    logic [RW:0]     rd_sum;
    logic [RW-1:0]   rd_phys;
    logic            rd_in_range;
    logic [7:0]      put_char;
    logic            out_free;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     mem_rdata;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        return (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
    endfunction

    function automatic logic [RW-1:0] row_dec(input logic [RW-1:0] r);
        return (r == '0) ? RW'(ROWS - 1) : r - 1'b1;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [SCW-1:0] c);
        return AW'(r) * AW'(COLS) + AW'(c);
    endfunction

    assign cur_col  = lc_reg[lc_bot_reg];
    assign put_char = (item_reg.char_code == CH_TAB) ? CH_SPACE : item_reg.char_code;
    assign out_free = !out_valid_reg || !out_stall;

    // screen rows are stored rotated: logical row i sits in row (i + row_base)
    always_comb
    begin
        rd_in_range = (32'(item_reg.read_row) < ROWS) && (32'(item_reg.read_col) < COLS);
        rd_sum      = {1'b0, RW'(item_reg.read_row)} + {1'b0, row_base_reg};
        if (rd_sum >= (RW + 1)'(ROWS))
        begin
            rd_sum = rd_sum - (RW + 1)'(ROWS);
        end
        rd_phys = rd_sum[RW-1:0];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr(scr_bot_reg, wr_col_reg);
        mem_wdata = wr_data_reg;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(rd_phys, SCW'(item_reg.read_col));
        case (state_reg)
            S_PUT:
            begin
                mem_we = row_valid_reg[scr_bot_reg];
            end
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(scr_bot_reg, sweep_reg);
                mem_wdata = BLANK_CELL;
            end
            S_DISPATCH:
            begin
                mem_re = (item_reg.kind == KIND_READ) && rd_in_range;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    tcw_screen_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_screen_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            text_color_reg <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                lc_reg[i] <= '0;
            end
            lc_bot_reg     <= RW'(ROWS - 1);
            row_base_reg   <= '0;
            scr_bot_reg    <= RW'(ROWS - 1);
            row_valid_reg  <= '0;
            rep_reg        <= '0;
            wr_col_reg     <= '0;
            wr_data_reg    <= '0;
            sweep_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            cell_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                text_color_reg <= cfg_data;
            end
            // a new result loaded in the same cycle takes over the register
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    cell_reg <= '0;
                    case (item_reg.kind)
                        KIND_PUT:
                        begin
                            if (item_reg.char_code == CH_NEWLINE)
                            begin
                                // scroll up: old top row becomes the empty bottom row
                                lc_bot_reg                <= row_dec(lc_bot_reg);
                                lc_reg[row_dec(lc_bot_reg)] <= '0;
                                row_base_reg              <= row_inc(row_base_reg);
                                scr_bot_reg               <= row_inc(scr_bot_reg);
                                row_valid_reg[row_base_reg] <= 1'b0;
                                state_reg                 <= S_FINISH;
                            end
                            else if (item_reg.char_code == CH_BACKSPACE)
                            begin
                                if (cur_col != '0)
                                begin
                                    lc_reg[lc_bot_reg] <= cur_col - 1'b1;
                                    wr_col_reg         <= SCW'(cur_col - 1'b1);
                                    wr_data_reg        <= ERASED_CELL;
                                    rep_reg            <= '0;
                                    state_reg          <= S_PUT;
                                end
                                else
                                begin
                                    // scroll down: old bottom row becomes the empty top row
                                    lc_bot_reg   <= row_inc(lc_bot_reg);
                                    row_base_reg <= row_dec(row_base_reg);
                                    scr_bot_reg  <= row_dec(scr_bot_reg);
                                    row_valid_reg[scr_bot_reg] <= 1'b0;
                                    state_reg    <= S_FINISH;
                                end
                            end
                            else if (item_reg.char_code == CH_TAB)
                            begin
                                rep_reg   <= 2'(TAB_SPACES - 1);
                                state_reg <= S_PRINT;
                            end
                            else
                            begin
                                rep_reg   <= '0;
                                state_reg <= S_PRINT;
                            end
                        end
                        KIND_READ:
                        begin
                            if (rd_in_range)
                            begin
                                rd_valid_reg <= row_valid_reg[rd_phys];
                                state_reg    <= S_READ;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            row_valid_reg <= '0;
                            for (int i = 0; i < ROWS; i++)
                            begin
                                lc_reg[i] <= '0;
                            end
                            state_reg <= S_FINISH;
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end

                S_PRINT:
                begin
                    if (cur_col >= CW'(COLS))
                    begin
                        // wrap: scroll up, then print at column 0 next cycle
                        lc_bot_reg                <= row_dec(lc_bot_reg);
                        lc_reg[row_dec(lc_bot_reg)] <= '0;
                        row_base_reg              <= row_inc(row_base_reg);
                        scr_bot_reg               <= row_inc(scr_bot_reg);
                        row_valid_reg[row_base_reg] <= 1'b0;
                    end
                    else
                    begin
                        wr_col_reg         <= SCW'(cur_col);
                        wr_data_reg        <= {text_color_reg, put_char};
                        lc_reg[lc_bot_reg] <= cur_col + 1'b1;
                        state_reg          <= S_PUT;
                    end
                end

                S_PUT:
                begin
                    if (!row_valid_reg[scr_bot_reg])
                    begin
                        sweep_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                    else if (rep_reg != '0)
                    begin
                        rep_reg   <= rep_reg - 1'b1;
                        state_reg <= S_PRINT;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_SWEEP:
                begin
                    if (sweep_reg == SCW'(COLS - 1))
                    begin
                        row_valid_reg[scr_bot_reg] <= 1'b1;
                        state_reg                  <= S_PUT;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end

                S_READ:
                begin
                    cell_reg  <= rd_valid_reg ? mem_rdata : BLANK_CELL;
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_data_reg.cell_data  <= cell_reg;
                        out_data_reg.cursor_col <= 7'(cur_col);
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
